FILE: sv/csh_pkg.sv
// Shared types and constants for the clamped swing histogram.
// Used by csh_div, the top level, the checker and the bench; depends on nothing.
package csh_pkg;
	localparam int NUM_SAMPLES_DEF = 4;
	localparam int CELL_COUNT_DEF = 128;
	localparam int SPREAD_LIMIT_DEF = 31;
	localparam int COUNT_WIDTH_DEF = 32;

	localparam int CFG_W = 5;
	localparam int KIND_W = 2;
	localparam int SAMPLE_W = 2;
	localparam int CELL_W = 7;
	localparam int SWING_W = 12;
	localparam int IDX_W = 6;
	localparam int WF_W = 17;
	localparam int MEAN_W = 20;
	localparam int NB_W = 7;
	localparam int SUM_W = 48;
	localparam int QUOT_W = 21;
	localparam int WIN_Q = 15;
	localparam int MEAN_Q = 8;
	localparam int WIN_STEPS = 17;
	localparam int MEAN_STEPS = 21;
	localparam int STEP_W = 5;
	localparam logic [CFG_W-1:0] SPREAD_RESET = 5'd15;
	localparam logic [QUOT_W-1:0] MEAN_NEG_LIM = 21'd524288;
	localparam logic [QUOT_W-1:0] MEAN_POS_LIM = 21'd524287;

	typedef enum logic [KIND_W-1:0] {
		KIND_ADD = 2'd0,
		KIND_WIN = 2'd1,
		KIND_MEAN = 2'd2,
		KIND_CLEAR = 2'd3
	} kind_t;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_ADD_RD,
		ST_ADD_WR,
		ST_TOT_RD,
		ST_TOT_ACC,
		ST_POST,
		ST_TIE_RD,
		ST_TIE_ACC,
		ST_DIV_WAIT,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic start;
		logic mean_mode;
	} div_ctl_t;
endpackage

FILE: sv/csh_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Stand-alone; no package needed.
module csh_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input logic clk,
	input logic we,
	input logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input logic [WIDTH-1:0] wdata,
	input logic re,
	input logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

FILE: sv/csh_div.sv
// Shared restoring divider, one quotient bit per cycle.
// Depends on csh_pkg for the control struct and step counts.
module csh_div #(
	parameter int DEN_W = 39,
	parameter int REM_W = 60
) (
	input logic clk,
	input logic arst_n,
	input csh_pkg::div_ctl_t ctl,
	input logic [REM_W-1:0] num,
	input logic [DEN_W-1:0] den,
	output logic done,
	output logic [csh_pkg::QUOT_W-1:0] quot
);
	import csh_pkg::*;

	logic [REM_W-1:0] rem_q;
	logic [REM_W-1:0] dsr_q;
	logic [STEP_W-1:0] cnt_q;
	logic busy_q;
	logic ge;

	assign ge = rem_q >= dsr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done <= 1'b0;
			cnt_q <= '0;
		end else begin
			done <= 1'b0;
			if (ctl.start) begin
				busy_q <= 1'b1;
				cnt_q <= ctl.mean_mode ? STEP_W'(MEAN_STEPS) : STEP_W'(WIN_STEPS);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == STEP_W'(1)) begin
					busy_q <= 1'b0;
					done <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			// Divisor is aligned to the top quotient bit of the mode.
			rem_q <= ctl.mean_mode ? (num << MEAN_Q) : (num << WIN_Q);
			dsr_q <= ctl.mean_mode ? (REM_W'(den) << (MEAN_STEPS - 1))
				: (REM_W'(den) << (WIN_STEPS - 1));
			quot <= '0;
		end else if (busy_q) begin
			if (ge) begin
				rem_q <= rem_q - dsr_q;
			end
			dsr_q <= dsr_q >> 1;
			quot <= {quot[QUOT_W-2:0], ge};
		end
	end
endmodule

FILE: sv/clamped_swing_histogram.sv
// Top level of the clamped swing histogram: sequencer, row stores and output register.
// Depends on csh_pkg, csh_ram and csh_div.
//
// Usage. Words enter on the in channel (valid/ready) and results leave on the out
// channel (valid/ready). The cfg channel writes the spread register; it is always
// ready and should only be written while the block is idle.
// An add word reads the bin and the row sum, then writes both back.
// A clear word sweeps every bin address, one per cycle: NUM_SAMPLES*CELL_COUNT*
// (2*SPREAD_LIMIT+3) addresses, 33280 with the defaults. The same sweep runs right
// after reset, and in_ready stays low until it is done.
// A readout or mean word first sums the row, reading and then adding each of its
// 2*s+3 bins for spread s. A readout then gives 2*s+1 words, each from a tie bin
// read and, for a nonempty row, 17 steps of the shared divider. A mean word gives
// one word after a setup state, 21 divider steps (nonempty row) and the emit state.
// Rate is set by the single bin read port and the bit-serial divider; the block
// takes one word at a time and in_ready is low while one is in work.
// A result sits in the output register until taken; while the receiver stalls the
// sequencer waits with the next result, so nothing is dropped.
module clamped_swing_histogram #(
	parameter int NUM_SAMPLES = csh_pkg::NUM_SAMPLES_DEF,
	parameter int CELL_COUNT = csh_pkg::CELL_COUNT_DEF,
	parameter int SPREAD_LIMIT = csh_pkg::SPREAD_LIMIT_DEF,
	parameter int COUNT_WIDTH = csh_pkg::COUNT_WIDTH_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [csh_pkg::CFG_W-1:0] cfg_data,
	input logic in_valid,
	output logic in_ready,
	input logic [csh_pkg::KIND_W-1:0] kind,
	input logic [csh_pkg::SAMPLE_W-1:0] sample,
	input logic [csh_pkg::CELL_W-1:0] cell_req,
	input logic signed [csh_pkg::SWING_W-1:0] swing,
	output logic out_valid,
	input logic out_ready,
	output logic [csh_pkg::IDX_W-1:0] spread_index,
	output logic [csh_pkg::WF_W-1:0] win_fraction,
	output logic signed [csh_pkg::MEAN_W-1:0] mean_swing,
	output logic no_data,
	output logic last
);
	import csh_pkg::*;

	localparam int ROW_STRIDE = 2 * SPREAD_LIMIT + 3;
	localparam int NUM_ROWS = NUM_SAMPLES * CELL_COUNT;
	localparam int BIN_DEPTH = NUM_ROWS * ROW_STRIDE;
	localparam int BIN_AW = BIN_DEPTH > 1 ? $clog2(BIN_DEPTH) : 1;
	localparam int SUM_AW = NUM_ROWS > 1 ? $clog2(NUM_ROWS) : 1;
	localparam int TOT_W = COUNT_WIDTH + NB_W;
	localparam int REM_W = (TOT_W + QUOT_W > SUM_W + MEAN_Q) ? TOT_W + QUOT_W
		: SUM_W + MEAN_Q;
	localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

	state_t state_q, state_d;
	kind_t kind_q;
	logic [CFG_W-1:0] spread_q;
	logic [CFG_W-1:0] ms_q;
	logic row_ok_q;
	logic [BIN_AW-1:0] base_q;
	logic [SUM_AW-1:0] row_q;
	logic signed [SWING_W-1:0] swing_q;
	logic [NB_W-1:0] bidx_q;
	logic [NB_W-1:0] idx_q;
	logic [TOT_W-1:0] total_q;
	logic [TOT_W-1:0] above_q;
	logic [COUNT_WIDTH-1:0] tie_q;
	logic [SUM_W-1:0] sum_q;
	logic [BIN_AW-1:0] clr_q;
	logic [WF_W-1:0] wf_q;
	logic [MEAN_W-1:0] mean_q;

	// Effective spread and the add bin index, worked out as a word is taken.
	logic [CFG_W-1:0] eff;
	logic [NB_W-1:0] nbm1_eff;
	logic signed [13:0] bsum;
	logic [NB_W-1:0] bidx_new;
	logic row_ok_new;
	logic [SUM_AW-1:0] row_new;
	logic [BIN_AW-1:0] base_new;

	// Per-word spread values.
	logic [NB_W-1:0] nbm1;
	logic [NB_W-1:0] kmax;
	logic [NB_W-1:0] rd_off;

	// Memory ports.
	logic bin_we, bin_re, sum_we, sum_re;
	logic [BIN_AW-1:0] bin_waddr, bin_raddr;
	logic [COUNT_WIDTH-1:0] bin_wdata, bin_rd;
	logic [SUM_AW-1:0] sum_waddr;
	logic [SUM_W-1:0] sum_wdata, sum_rd;
	logic signed [SUM_W:0] sum_ext;
	logic [SUM_W-1:0] sum_sat;
	logic [SUM_W-1:0] mag;

	// Divider.
	div_ctl_t div_ctl;
	logic [REM_W-1:0] div_num;
	logic div_done;
	logic [QUOT_W-1:0] div_quot;
	logic [QUOT_W-1:0] mean_lim;

	logic accept;
	logic out_free;
	logic clr_last;
	logic win_last;

	assign cfg_ready = 1'b1;
	assign in_ready = (state_q == ST_IDLE);
	assign accept = in_valid && in_ready;
	assign out_free = !out_valid || out_ready;
	assign clr_last = (clr_q == BIN_AW'(BIN_DEPTH - 1));

	always_comb begin
		if (spread_q == '0) begin
			eff = CFG_W'(1);
		end else if (spread_q > CFG_W'(SPREAD_LIMIT)) begin
			eff = CFG_W'(SPREAD_LIMIT);
		end else begin
			eff = spread_q;
		end
		nbm1_eff = {1'b0, eff, 1'b0} + NB_W'(2);
		bsum = {{2{swing[SWING_W-1]}}, swing} + $signed({9'd0, eff}) + 14'sd1;
		if (bsum[13]) begin
			bidx_new = '0;
		end else if (bsum > $signed({7'd0, nbm1_eff})) begin
			bidx_new = nbm1_eff;
		end else begin
			bidx_new = bsum[NB_W-1:0];
		end
		row_ok_new = (int'(sample) < NUM_SAMPLES) && (int'(cell_req) < CELL_COUNT);
		row_new = row_ok_new ? SUM_AW'(int'(sample) * CELL_COUNT + int'(cell_req)) : '0;
		base_new = BIN_AW'(int'(row_new) * ROW_STRIDE);
	end

	assign nbm1 = {1'b0, ms_q, 1'b0} + NB_W'(2);
	assign kmax = {1'b0, ms_q, 1'b0};
	assign win_last = (idx_q == kmax);
	// Readout walks the tie bin downward from just below the top bin.
	assign rd_off = (state_q == ST_TIE_RD) ? (kmax + NB_W'(1) - idx_q) : idx_q;

	// Bin store.
	assign bin_we = (state_q == ST_CLEAR) || (state_q == ST_ADD_WR);
	assign bin_waddr = (state_q == ST_CLEAR) ? clr_q : base_q + BIN_AW'(bidx_q);
	assign bin_wdata = (state_q == ST_CLEAR) ? '0
		: ((bin_rd == COUNT_MAX) ? bin_rd : bin_rd + 1'b1);
	assign bin_re = (state_q == ST_ADD_RD) || (state_q == ST_TOT_RD)
		|| (state_q == ST_TIE_RD);
	assign bin_raddr = (state_q == ST_ADD_RD) ? base_q + BIN_AW'(bidx_q)
		: base_q + BIN_AW'(rd_off);

	// Swing sum store, saturating at the signed limits.
	always_comb begin
		sum_ext = $signed({sum_rd[SUM_W-1], sum_rd})
			+ $signed({{(SUM_W + 1 - SWING_W){swing_q[SWING_W-1]}}, swing_q});
		if (sum_ext[SUM_W] != sum_ext[SUM_W-1]) begin
			sum_sat = sum_ext[SUM_W] ? {1'b1, {(SUM_W - 1){1'b0}}}
				: {1'b0, {(SUM_W - 1){1'b1}}};
		end else begin
			sum_sat = sum_ext[SUM_W-1:0];
		end
	end

	assign sum_we = ((state_q == ST_CLEAR) && (int'(clr_q) < NUM_ROWS))
		|| (state_q == ST_ADD_WR);
	assign sum_waddr = (state_q == ST_CLEAR) ? clr_q[SUM_AW-1:0] : row_q;
	assign sum_wdata = (state_q == ST_CLEAR) ? '0 : sum_sat;
	assign sum_re = (state_q == ST_ADD_RD) || (state_q == ST_TOT_RD);

	csh_ram #(.WIDTH(COUNT_WIDTH), .DEPTH(BIN_DEPTH)) u_bins (
		.clk(clk),
		.we(bin_we),
		.waddr(bin_waddr),
		.wdata(bin_wdata),
		.re(bin_re),
		.raddr(bin_raddr),
		.rdata(bin_rd)
	);

	csh_ram #(.WIDTH(SUM_W), .DEPTH(NUM_ROWS)) u_sums (
		.clk(clk),
		.we(sum_we),
		.waddr(sum_waddr),
		.wdata(sum_wdata),
		.re(sum_re),
		.raddr(row_q),
		.rdata(sum_rd)
	);

	// Divider feed: tail count for readouts, scaled magnitude for the mean.
	assign mag = sum_q[SUM_W-1] ? (~sum_q + 1'b1) : sum_q;

	always_comb begin
		div_ctl.start = 1'b0;
		div_ctl.mean_mode = (kind_q == KIND_MEAN);
		if (state_q == ST_TIE_ACC) begin
			div_ctl.start = (total_q != '0);
			div_num = REM_W'({above_q, 1'b0} + (TOT_W + 1)'(bin_rd));
		end else begin
			div_ctl.start = (state_q == ST_POST) && (kind_q == KIND_MEAN)
				&& (total_q != '0);
			div_num = REM_W'(mag);
		end
	end

	csh_div #(.DEN_W(TOT_W), .REM_W(REM_W)) u_div (
		.clk(clk),
		.arst_n(arst_n),
		.ctl(div_ctl),
		.num(div_num),
		.den(total_q),
		.done(div_done),
		.quot(div_quot)
	);

	assign mean_lim = sum_q[SUM_W-1] ? MEAN_NEG_LIM : MEAN_POS_LIM;

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR: begin
				if (clr_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (accept) begin
					case (kind_t'(kind))
						KIND_CLEAR: state_d = ST_CLEAR;
						KIND_ADD: state_d = row_ok_new ? ST_ADD_RD : ST_IDLE;
						default: state_d = row_ok_new ? ST_TOT_RD : ST_POST;
					endcase
				end
			end
			ST_ADD_RD: state_d = ST_ADD_WR;
			ST_ADD_WR: state_d = ST_IDLE;
			ST_TOT_RD: state_d = ST_TOT_ACC;
			ST_TOT_ACC: state_d = (idx_q == nbm1) ? ST_POST : ST_TOT_RD;
			ST_POST: begin
				if (kind_q == KIND_WIN) begin
					state_d = ST_TIE_RD;
				end else begin
					state_d = (total_q != '0) ? ST_DIV_WAIT : ST_EMIT;
				end
			end
			ST_TIE_RD: state_d = ST_TIE_ACC;
			ST_TIE_ACC: state_d = (total_q != '0) ? ST_DIV_WAIT : ST_EMIT;
			ST_DIV_WAIT: begin
				if (div_done) begin
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (out_free) begin
					if (kind_q == KIND_WIN && !win_last) begin
						state_d = ST_TIE_RD;
					end else begin
						state_d = ST_IDLE;
					end
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			spread_q <= SPREAD_RESET;
			clr_q <= '0;
			out_valid <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_valid && cfg_ready) begin
				spread_q <= cfg_data;
			end
			if (state_q == ST_CLEAR) begin
				clr_q <= clr_last ? '0 : clr_q + 1'b1;
			end
			if (state_q == ST_EMIT && out_free) begin
				out_valid <= 1'b1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
		end
	end

	// Word datapath.
	always_ff @(posedge clk) begin
		if (accept) begin
			kind_q <= kind_t'(kind);
			ms_q <= eff;
			row_ok_q <= row_ok_new;
			row_q <= row_new;
			base_q <= base_new;
			swing_q <= swing;
			bidx_q <= bidx_new;
			idx_q <= '0;
			total_q <= '0;
			above_q <= '0;
			sum_q <= '0;
		end
		if (state_q == ST_TOT_ACC) begin
			total_q <= total_q + TOT_W'(bin_rd);
			sum_q <= sum_rd;
			if (idx_q == nbm1) begin
				above_q <= TOT_W'(bin_rd);
				idx_q <= '0;
			end else begin
				idx_q <= idx_q + 1'b1;
			end
		end
		if (state_q == ST_POST) begin
			wf_q <= '0;
			mean_q <= '0;
		end
		if (state_q == ST_TIE_ACC) begin
			tie_q <= row_ok_q ? bin_rd : '0;
			wf_q <= '0;
		end
		if (state_q == ST_DIV_WAIT && div_done) begin
			if (kind_q == KIND_WIN) begin
				wf_q <= div_quot[WF_W-1:0];
			end else if (div_quot > mean_lim) begin
				mean_q <= sum_q[SUM_W-1] ? MEAN_W'(~mean_lim + 1'b1) : MEAN_W'(mean_lim);
			end else begin
				mean_q <= sum_q[SUM_W-1] ? MEAN_W'(~div_quot + 1'b1) : MEAN_W'(div_quot);
			end
		end
		if (state_q == ST_EMIT && out_free) begin
			no_data <= (total_q == '0);
			if (kind_q == KIND_WIN) begin
				spread_index <= idx_q[IDX_W-1:0];
				win_fraction <= wf_q;
				mean_swing <= '0;
				last <= win_last;
				above_q <= above_q + TOT_W'(tie_q);
				idx_q <= idx_q + 1'b1;
			end else begin
				spread_index <= '0;
				win_fraction <= '0;
				mean_swing <= mean_q;
				last <= 1'b1;
			end
		end
	end
endmodule

FILE: sv/csh_checker.sv
// Port-level checker for the clamped swing histogram, bound to the top level.
// Depends on csh_pkg for port widths.
module csh_checker (
	input logic clk,
	input logic arst_n,
	input logic out_valid,
	input logic out_ready,
	input logic [csh_pkg::IDX_W-1:0] spread_index,
	input logic [csh_pkg::WF_W-1:0] win_fraction,
	input logic signed [csh_pkg::MEAN_W-1:0] mean_swing,
	input logic no_data,
	input logic last
);
	// A stalled result word keeps its value fields, spread index and last flag.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(win_fraction)
			&& $stable(mean_swing) && $stable(spread_index) && $stable(last))
		else $error("result word changed while stalled");

	// A win fraction never exceeds one in Q16.
	a_wf_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> win_fraction <= 17'd65536)
		else $error("win fraction above one");

	// An empty row gives zero in both value fields.
	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && no_data |-> win_fraction == '0 && mean_swing == '0)
		else $error("empty row with nonzero value");

	// A nonzero mean comes only as the single last word of its run.
	a_mean_single: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && mean_swing != '0 |-> spread_index == '0 && last
			&& win_fraction == '0)
		else $error("mean word malformed");
endmodule

bind clamped_swing_histogram csh_checker u_csh_checker (.*);

FILE: bench/clamped_swing_histogram_tb.sv
// Self-checking bench for clamped_swing_histogram: directed and random words with
// idling, stalls and back-pressure.
// Depends on csh_pkg and the block's RTL; needs no files or arguments.
module clamped_swing_histogram_tb;
	import csh_pkg::*;

	localparam int ROWS = 512;
	localparam int STRIDE = 65;
	localparam int QUIET_LIMIT = 150000;
	localparam longint SUM_HI = 64'sh0000_7FFF_FFFF_FFFF;
	localparam longint SUM_LO = -SUM_HI - 1;
	localparam longint unsigned COUNT_SAT = 64'hFFFF_FFFF;

	typedef struct {
		logic [IDX_W-1:0] idx;
		logic [WF_W-1:0] wf;
		logic [MEAN_W-1:0] mean;
		logic nd;
		logic lst;
	} tail_word_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_W-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [KIND_W-1:0] kind = '0;
	logic [SAMPLE_W-1:0] sample = '0;
	logic [CELL_W-1:0] cell_req = '0;
	logic signed [SWING_W-1:0] swing = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [IDX_W-1:0] spread_index;
	logic [WF_W-1:0] win_fraction;
	logic signed [MEAN_W-1:0] mean_swing;
	logic no_data;
	logic last;

	// Mirror of the block's row store and register.
	longint unsigned bin_mirror[ROWS][STRIDE];
	longint sum_mirror[ROWS];
	int spread_reg = 15;
	tail_word_t pending_words[$];

	int fail_count = 0;
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int hold_cycles = 0;
	int quiet_cycles = 0;

	clamped_swing_histogram dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready),
		.kind(kind), .sample(sample), .cell_req(cell_req), .swing(swing),
		.out_valid(out_valid), .out_ready(out_ready),
		.spread_index(spread_index), .win_fraction(win_fraction),
		.mean_swing(mean_swing), .no_data(no_data), .last(last)
	);

	always #2 clk = ~clk;

	// Receiver: a long hold-off when asked, otherwise random stalls.
	always @(negedge clk) begin
		if (hold_cycles > 0) begin
			hold_cycles <= hold_cycles - 1;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
		end
	end

	// Result checker: each accepted word is matched with the oldest prediction.
	always @(posedge clk) begin
		if (out_valid && out_ready) begin
			tail_word_t e;
			if (pending_words.size() == 0) begin
				$error("result word with nothing expected");
				fail_count++;
			end else begin
				e = pending_words.pop_front();
				if (spread_index !== e.idx) begin
					$error("spread_index expected %0d got %0d", e.idx, spread_index);
					fail_count++;
				end
				if (win_fraction !== e.wf) begin
					$error("win_fraction expected %0d got %0d", e.wf, win_fraction);
					fail_count++;
				end
				if (mean_swing !== e.mean) begin
					$error("mean_swing expected %0d got %0d", $signed(e.mean), mean_swing);
					fail_count++;
				end
				if (no_data !== e.nd) begin
					$error("no_data expected %0b got %0b", e.nd, no_data);
					fail_count++;
				end
				if (last !== e.lst) begin
					$error("last expected %0b got %0b", e.lst, last);
					fail_count++;
				end
			end
		end
	end

	// Watchdog on cycles without any handshake. The clearing pass after reset
	// and after every clear word fits well inside the limit.
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	function automatic void clear_mirror();
		foreach (bin_mirror[r, b]) bin_mirror[r][b] = 0;
		foreach (sum_mirror[r]) sum_mirror[r] = 0;
	endfunction

	// Applies one accepted word to the mirror and queues the words it yields.
	function automatic void predict_histogram(kind_t k, int row, int sw);
		int ms, nb, bin;
		longint unsigned total, above, tie, mag, q;
		longint s;
		tail_word_t w;
		ms = (spread_reg == 0) ? 1 : spread_reg;
		nb = 2 * ms + 3;
		total = 0;
		case (k)
			KIND_CLEAR: begin
				clear_mirror();
			end
			KIND_ADD: begin
				bin = sw + ms + 1;
				if (bin < 0) bin = 0;
				if (bin > nb - 1) bin = nb - 1;
				if (bin_mirror[row][bin] < COUNT_SAT) bin_mirror[row][bin]++;
				s = sum_mirror[row] + sw;
				if (s > SUM_HI) s = SUM_HI;
				if (s < SUM_LO) s = SUM_LO;
				sum_mirror[row] = s;
			end
			default: begin
				for (int i = 0; i < nb; i++) total += bin_mirror[row][i];
				w.nd = (total == 0);
				if (k == KIND_WIN) begin
					above = bin_mirror[row][nb-1];
					for (int i = 0; i < 2 * ms + 1; i++) begin
						tie = bin_mirror[row][nb-2-i];
						w.idx = IDX_W'(i);
						w.wf = (total == 0) ? '0
							: WF_W'(((2 * above + tie) << WIN_Q) / total);
						w.mean = '0;
						w.lst = (i == 2 * ms);
						pending_words.push_back(w);
						above += tie;
					end
				end else begin
					// Mean swing: magnitude divided and saturated, then sign restored.
					s = sum_mirror[row];
					w.idx = '0;
					w.wf = '0;
					w.lst = 1'b1;
					w.mean = '0;
					if (total != 0) begin
						mag = (s < 0) ? longint'(-s) : longint'(s);
						q = (mag << MEAN_Q) / total;
						if (s < 0) begin
							if (q > 524288) q = 524288;
							w.mean = MEAN_W'(-longint'(q));
						end else begin
							if (q > 524287) q = 524287;
							w.mean = MEAN_W'(q);
						end
					end
					pending_words.push_back(w);
				end
			end
		endcase
	endfunction

	// Offers one word, idling first at the current rate, and returns once it is taken.
	// Valid is left high; the next word or an explicit drop follows at a later edge.
	task automatic send_word(kind_t k, int smp, int cell_idx, int sw);
		@(negedge clk);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		kind <= k;
		sample <= SAMPLE_W'(smp);
		cell_req <= CELL_W'(cell_idx);
		swing <= SWING_W'(sw);
		in_valid <= 1'b1;
		do @(posedge clk); while (!in_ready);
		predict_histogram(k, smp * 128 + cell_idx, sw);
	endtask

	task automatic drop_valid();
		@(negedge clk);
		in_valid <= 1'b0;
	endtask

	// Sender pause until every expected word has come back.
	task automatic drain_results();
		drop_valid();
		while (pending_words.size() != 0) @(posedge clk);
	endtask

	// Register writes only with the block idle: drained, a wait for a late add to
	// finish, then in_ready high so a clearing sweep has ended too.
	task automatic write_spread(int value);
		drain_results();
		repeat (8) @(posedge clk);
		while (!in_ready) @(posedge clk);
		@(negedge clk);
		cfg_data <= CFG_W'(value);
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		spread_reg = value;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic test_directed();
		send_idle_pct = 0;
		recv_idle_pct = 0;
		// Empty row readout and mean give no_data.
		send_word(KIND_WIN, 1, 5, 0);
		send_word(KIND_MEAN, 1, 5, 0);
		// Swing extremes and the clamp on both ends of the bin range.
		send_word(KIND_ADD, 0, 0, -2048);
		send_word(KIND_ADD, 0, 0, 2047);
		send_word(KIND_ADD, 0, 0, 0);
		send_word(KIND_ADD, 0, 0, -1);
		send_word(KIND_ADD, 0, 0, 15);
		send_word(KIND_ADD, 0, 0, -16);
		send_word(KIND_ADD, 0, 0, 16);
		send_word(KIND_WIN, 0, 0, 0);
		send_word(KIND_MEAN, 0, 0, 0);
		send_word(KIND_ADD, 3, 127, -2048);
		send_word(KIND_ADD, 3, 127, -2048);
		send_word(KIND_MEAN, 3, 127, 0);
		send_word(KIND_WIN, 3, 127, 0);
		// A clear empties every row.
		send_word(KIND_CLEAR, 2, 64, 1365);
		send_word(KIND_WIN, 0, 0, 0);
		send_word(KIND_MEAN, 3, 127, 0);
		drain_results();
	endtask

	// Spread register extremes, including zero acting as one, and a change with data kept.
	task automatic test_spread_extremes();
		write_spread(0);
		send_word(KIND_ADD, 2, 3, -2);
		send_word(KIND_ADD, 2, 3, 1);
		send_word(KIND_ADD, 2, 3, 5);
		send_word(KIND_WIN, 2, 3, 0);
		write_spread(31);
		send_word(KIND_WIN, 2, 3, 0);
		send_word(KIND_ADD, 2, 3, 31);
		send_word(KIND_ADD, 2, 3, -32);
		send_word(KIND_WIN, 2, 3, 0);
		send_word(KIND_MEAN, 2, 3, 0);
		write_spread(1);
		send_word(KIND_WIN, 2, 3, 0);
		drain_results();
	endtask

	// Mostly adds on four hot rows with swings near the bin range, mixed with readouts, means and rare clears.
	task automatic test_random(int count, int s_pct, int r_pct);
		int hot_s[4] = '{0, 3, 1, 2};
		int hot_c[4] = '{0, 127, 42, 85};
		int pick, ms, sw, r;
		kind_t k;
		send_idle_pct = s_pct;
		recv_idle_pct = r_pct;
		for (int n = 0; n < count; n++) begin
			ms = (spread_reg == 0) ? 1 : spread_reg;
			pick = $urandom_range(0, 3);
			r = $urandom_range(0, 199);
			if (r < 1) k = KIND_CLEAR;
			else if (r < 150) k = KIND_ADD;
			else if (r < 180) k = KIND_WIN;
			else k = KIND_MEAN;
			if ($urandom_range(0, 9) == 0)
				sw = $signed(12'($urandom));
			else
				sw = $urandom_range(0, 2 * ms + 4) - ms - 2;
			if ($urandom_range(0, 9) == 0)
				send_word(k, $urandom_range(0, 3), $urandom_range(0, 127), sw);
			else
				send_word(k, hot_s[pick], hot_c[pick], sw);
		end
		drain_results();
	endtask

	// Long receiver hold-off while the sender keeps offering words.
	task automatic test_backpressure();
		send_idle_pct = 0;
		recv_idle_pct = 0;
		hold_cycles = 400;
		send_word(KIND_ADD, 1, 1, 2);
		send_word(KIND_WIN, 1, 1, 0);
		send_word(KIND_MEAN, 1, 1, 0);
		send_word(KIND_WIN, 1, 1, 0);
		send_word(KIND_ADD, 1, 1, -3);
		send_word(KIND_MEAN, 1, 1, 0);
		drain_results();
	endtask

	initial begin
		clear_mirror();
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		test_directed();
		test_spread_extremes();
		write_spread(7);
		test_random(130, 38, 63);
		test_backpressure();
		write_spread(3);
		test_random(130, 63, 38);
		write_spread(22);
		test_random(110, 0, 0);
		drain_results();
		repeat (40) @(posedge clk);
		if (fail_count == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end
endmodule
